@@ rtl/pce_pkg.sv @@
package pce_pkg;

   // Fixed field widths
   localparam int ANGLE_W    = 32;
   localparam int AXIS_W     = 32;
   localparam int OUT_W      = 48;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Defaults for the top-level parameters
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 18;

   // Angle datapath: reduced angle is unsigned Q3.30 below 2*pi, CORDIC runs signed
   localparam int R_W  = 33;
   localparam int CW   = 34;
   localparam int Q30_SHIFT = 30;

   localparam logic [R_W-1:0] Q30_TWO_PI      = 33'd6746518852;
   localparam logic [R_W-1:0] Q30_PI          = 33'd3373259426;
   localparam logic [R_W-1:0] Q30_HALF_PI     = 33'd1686629713;
   localparam logic [R_W-1:0] Q30_THREE_HALF  = 33'd5059889139;
   localparam logic [R_W-1:0] Q30_INV_GAIN    = 33'd652032874;

   // Product widths: unsigned 32-bit operand times signed operand
   localparam int PROD_W = AXIS_W + 1 + CW;
   localparam int ZP_W   = AXIS_W + 1 + ANGLE_W;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [AXIS_W-1:0] AXIS_RESET = 32'h0001_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_CIRCLE  = 2'd0,
      KIND_ELLIPSE = 2'd1,
      KIND_HELIX   = 2'd2,
      KIND_SPARE   = 2'd3
   } pce_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KIND   = 2'd0,
      CSR_AXIS_A = 2'd1,
      CSR_AXIS_B = 2'd2,
      CSR_PITCH  = 2'd3
   } pce_csr_type;

   typedef enum logic {
      OP_POINT = 1'b0,
      OP_DERIV = 1'b1
   } pce_op_type;

   typedef struct packed {
      logic                      valid;
      pce_op_type                op;
      logic signed [ANGLE_W-1:0] angle;
   } pce_tag_type;

   typedef struct packed {
      pce_kind_type      kind;
      logic [AXIS_W-1:0] axis_a;
      logic [AXIS_W-1:0] axis_b;
      logic [AXIS_W-1:0] pitch;
   } pce_cfg_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
   } pce_res_type;

   // round(atan(2^-idx) * 2^30)
   function automatic logic signed [CW-1:0] atan_entry(input int idx);
      logic signed [CW-1:0] val;
      case (idx)
         0:       val = CW'(843314857);
         1:       val = CW'(497837829);
         2:       val = CW'(263043837);
         3:       val = CW'(133525159);
         4:       val = CW'(67021687);
         5:       val = CW'(33543516);
         6:       val = CW'(16775851);
         7:       val = CW'(8388437);
         8:       val = CW'(4194283);
         9:       val = CW'(2097149);
         10:      val = CW'(1048576);
         default: val = (idx <= 30) ? (CW'(1) << (30 - idx)) : '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/pce_reduce.sv @@
module pce_reduce import pce_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  pce_op_type                in_op,
   input  logic signed [ANGLE_W-1:0] in_angle,
   output pce_tag_type               out_tag,
   output logic signed [CW-1:0]      out_z,
   output logic                      out_neg
);

   localparam int SCALE_SH  = Q30_SHIFT - FRAC_BITS;
   localparam int V_W       = ANGLE_W + SCALE_SH;
   localparam int RED_STEPS = SCALE_SH;
   localparam int U_W       = V_W + 1;
   // A multiple of 2*pi that lifts every scaled angle to a non-negative value
   localparam logic [U_W-1:0] OFFSET = U_W'(Q30_TWO_PI) << (RED_STEPS - 1);

   logic [U_W-1:0]        u_ff   [RED_STEPS+1];
   pce_tag_type           tag_ff [RED_STEPS+1];
   logic signed [V_W-1:0] v_ext;
   logic signed [V_W-1:0] v_scaled;
   logic [U_W-1:0]        u_in;
   pce_tag_type           tag_in;

   always_comb begin
      v_ext    = V_W'(in_angle);
      v_scaled = v_ext <<< SCALE_SH;
      u_in     = U_W'(v_scaled) + OFFSET;
      tag_in   = '{valid: in_valid, op: in_op, angle: in_angle};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0].valid <= 1'b0;
      end else if (advance) begin
         tag_ff[0] <= tag_in;
         u_ff[0]   <= u_in;
      end
   end

   // Restoring reduction: one multiple of 2*pi per stage, largest first
   for (genvar j = 0; j < RED_STEPS; j++) begin : g_step
      localparam logic [U_W-1:0] STEP_C = U_W'(Q30_TWO_PI) << (RED_STEPS - 1 - j);
      logic [U_W:0]   diff;
      logic [U_W-1:0] u_step_in;

      always_comb begin
         diff      = {1'b0, u_ff[j]} - {1'b0, STEP_C};
         u_step_in = diff[U_W] ? u_ff[j] : diff[U_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j+1].valid <= 1'b0;
         end else if (advance) begin
            tag_ff[j+1] <= tag_ff[j];
            u_ff[j+1]   <= u_step_in;
         end
      end
   end

   // Fold [0, 2*pi) into [-pi/2, pi/2], noting a sign flip of sin and cos
   logic [R_W-1:0]       r;
   logic signed [CW-1:0] r_s;
   logic signed [CW-1:0] z_in;
   logic                 neg_in;
   logic signed [CW-1:0] z_ff;
   logic                 neg_ff;
   pce_tag_type          fold_tag_ff;

   always_comb begin
      r   = u_ff[RED_STEPS][R_W-1:0];
      r_s = $signed(CW'(r));
      if (r <= Q30_HALF_PI) begin
         z_in   = r_s;
         neg_in = 1'b0;
      end else if (r < Q30_THREE_HALF) begin
         z_in   = r_s - $signed(CW'(Q30_PI));
         neg_in = 1'b1;
      end else begin
         z_in   = r_s - $signed(CW'(Q30_TWO_PI));
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         fold_tag_ff <= tag_ff[RED_STEPS];
         z_ff        <= z_in;
         neg_ff      <= neg_in;
      end
   end

   assign out_tag = fold_tag_ff;
   assign out_z   = z_ff;
   assign out_neg = neg_ff;

endmodule

@@ rtl/pce_cordic.sv @@
module pce_cordic import pce_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  pce_tag_type          in_tag,
   input  logic signed [CW-1:0] in_z,
   input  logic                 in_neg,
   output pce_tag_type          out_tag,
   output logic signed [CW-1:0] out_cos,
   output logic signed [CW-1:0] out_sin,
   output logic                 out_neg
);

   localparam logic signed [CW-1:0] X_INIT = $signed(CW'(Q30_INV_GAIN));

   logic signed [CW-1:0] x_ff   [CORDIC_STEPS];
   logic signed [CW-1:0] y_ff   [CORDIC_STEPS];
   logic signed [CW-1:0] z_ff   [CORDIC_STEPS-1];
   logic                 neg_ff [CORDIC_STEPS];
   pce_tag_type          tag_ff [CORDIC_STEPS];

   logic signed [CW-1:0] x_q   [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_q   [CORDIC_STEPS+1];
   logic signed [CW-1:0] z_q   [CORDIC_STEPS];
   logic                 neg_q [CORDIC_STEPS+1];
   pce_tag_type          tag_q [CORDIC_STEPS+1];

   assign x_q[0]   = X_INIT;
   assign y_q[0]   = '0;
   assign z_q[0]   = in_z;
   assign neg_q[0] = in_neg;
   assign tag_q[0] = in_tag;

   // One rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      localparam logic signed [CW-1:0] ATAN_I = atan_entry(i);
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic                 dir;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;

      always_comb begin
         dx   = y_q[i] >>> i;
         dy   = x_q[i] >>> i;
         dir  = ~z_q[i][CW-1];
         x_in = dir ? (x_q[i] - dx) : (x_q[i] + dx);
         y_in = dir ? (y_q[i] + dy) : (y_q[i] - dy);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i].valid <= 1'b0;
         end else if (advance) begin
            tag_ff[i] <= tag_q[i];
            neg_ff[i] <= neg_q[i];
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
         end
      end

      assign x_q[i+1]   = x_ff[i];
      assign y_q[i+1]   = y_ff[i];
      assign neg_q[i+1] = neg_ff[i];
      assign tag_q[i+1] = tag_ff[i];

      // Residual angle is not needed after the last rotation
      if (i < CORDIC_STEPS - 1) begin : g_resid
         logic signed [CW-1:0] z_in;

         assign z_in = dir ? (z_q[i] - ATAN_I) : (z_q[i] + ATAN_I);

         always_ff @(posedge clock) begin
            if (advance) begin
               z_ff[i] <= z_in;
            end
         end

         assign z_q[i+1] = z_ff[i];
      end
   end

   assign out_tag = tag_q[CORDIC_STEPS];
   assign out_cos = x_q[CORDIC_STEPS];
   assign out_sin = y_q[CORDIC_STEPS];
   assign out_neg = neg_q[CORDIC_STEPS];

endmodule

@@ rtl/pce_scale.sv @@
module pce_scale import pce_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  pce_cfg_type          cfg,
   input  pce_tag_type          in_tag,
   input  logic signed [CW-1:0] in_cos,
   input  logic signed [CW-1:0] in_sin,
   input  logic                 in_neg,
   output logic                 out_valid,
   output pce_op_type           out_op,
   output pce_res_type          out_res
);

   localparam logic signed [PROD_W-1:0] RND_Q30 = PROD_W'(1) << (Q30_SHIFT - 1);
   localparam logic signed [ZP_W-1:0]   RND_F   = ZP_W'(1) << (FRAC_BITS - 1);

   // Stage A: undo the fold and pick the operand for each axis
   logic signed [CW-1:0] c_fix;
   logic signed [CW-1:0] s_fix;
   logic signed [CW-1:0] sel_x_in;
   logic signed [CW-1:0] sel_y_in;
   logic signed [CW-1:0] sel_x_ff;
   logic signed [CW-1:0] sel_y_ff;
   pce_tag_type          tag_a_ff;

   always_comb begin
      c_fix    = in_neg ? -in_cos : in_cos;
      s_fix    = in_neg ? -in_sin : in_sin;
      sel_x_in = (in_tag.op == OP_POINT) ? c_fix : s_fix;
      sel_y_in = (in_tag.op == OP_POINT) ? s_fix : c_fix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
      end else if (advance) begin
         tag_a_ff <= in_tag;
         sel_x_ff <= sel_x_in;
         sel_y_ff <= sel_y_in;
      end
   end

   // Stage B: the three multiplications
   logic [AXIS_W-1:0]        axis_y;
   logic signed [PROD_W-1:0] mul_a;
   logic signed [PROD_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_ox;
   logic signed [PROD_W-1:0] mul_oy;
   logic signed [ZP_W-1:0]   mul_p;
   logic signed [ZP_W-1:0]   mul_t;
   logic signed [PROD_W-1:0] prod_x_in;
   logic signed [PROD_W-1:0] prod_y_in;
   logic signed [ZP_W-1:0]   prod_z_in;
   logic signed [PROD_W-1:0] prod_x_ff;
   logic signed [PROD_W-1:0] prod_y_ff;
   logic signed [ZP_W-1:0]   prod_z_ff;
   logic                     valid_b_ff;
   pce_op_type               op_b_ff;

   always_comb begin
      axis_y    = (cfg.kind == KIND_ELLIPSE) ? cfg.axis_b : cfg.axis_a;
      mul_a     = PROD_W'($signed({1'b0, cfg.axis_a}));
      mul_b     = PROD_W'($signed({1'b0, axis_y}));
      mul_ox    = PROD_W'(sel_x_ff);
      mul_oy    = PROD_W'(sel_y_ff);
      mul_p     = ZP_W'($signed({1'b0, cfg.pitch}));
      mul_t     = ZP_W'(tag_a_ff.angle);
      prod_x_in = mul_a * mul_ox;
      prod_y_in = mul_b * mul_oy;
      prod_z_in = mul_p * mul_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_b_ff <= tag_a_ff.valid;
         op_b_ff    <= tag_a_ff.op;
         prod_x_ff  <= prod_x_in;
         prod_y_ff  <= prod_y_in;
         prod_z_ff  <= prod_z_in;
      end
   end

   // Stage C: round half up, saturate the helix height, choose z
   logic signed [PROD_W-1:0] sum_x;
   logic signed [PROD_W-1:0] sum_y;
   logic signed [ZP_W-1:0]   sum_z;
   logic signed [ZP_W-1:0]   sh_z;
   logic                     z_fits;
   logic signed [OUT_W-1:0]  z_sat;
   pce_res_type              res_in;
   pce_res_type              res_ff;
   logic                     valid_c_ff;
   pce_op_type               op_c_ff;

   always_comb begin
      sum_x    = prod_x_ff + RND_Q30;
      sum_y    = prod_y_ff + RND_Q30;
      sum_z    = prod_z_ff + RND_F;
      sh_z     = sum_z >>> FRAC_BITS;
      z_fits   = (&sh_z[ZP_W-1:OUT_W-1]) | ~(|sh_z[ZP_W-1:OUT_W-1]);
      z_sat    = z_fits ? sh_z[OUT_W-1:0] : (sh_z[ZP_W-1] ? OUT_MIN : OUT_MAX);
      res_in.x = OUT_W'(sum_x >>> Q30_SHIFT);
      res_in.y = OUT_W'(sum_y >>> Q30_SHIFT);
      if (cfg.kind != KIND_HELIX) begin
         res_in.z = '0;
      end else if (op_b_ff == OP_POINT) begin
         res_in.z = z_sat;
      end else begin
         res_in.z = {{(OUT_W-AXIS_W){1'b0}}, cfg.pitch};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (advance) begin
         valid_c_ff <= valid_b_ff;
         op_c_ff    <= op_b_ff;
         res_ff     <= res_in;
      end
   end

   assign out_valid = valid_c_ff;
   assign out_op    = op_c_ff;
   assign out_res   = res_ff;

endmodule

@@ rtl/parametric_curve_evaluator.sv @@
// Channel   Handshake               Payload
// req       req_valid / req_ready   req_operation, req_angle (signed Q16.16 at default FRAC_BITS)
// rsp       rsp_valid / rsp_ready   rsp_coord_x, rsp_coord_y, rsp_coord_z
// csr       csr_wen (no wait)       csr_index, csr_wdata
//
// One request per cycle is taken while req_ready is high; between a request and its response lie
// one register stage per angle-reduction subtract, one per CORDIC rotation, and input, fold,
// select, multiply, round and output stages around them.
// Reset clears all valid bits and loads the configuration registers with their reset values.
// A skid register behind the output holds one extra response; when it fills, req_ready
// drops and every stage holds until rsp_ready frees the output.
module parametric_curve_evaluator import pce_pkg::*; #(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic signed [ANGLE_W-1:0]    req_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_coord_x,
   output logic signed [OUT_W-1:0]      rsp_coord_y,
   output logic signed [OUT_W-1:0]      rsp_coord_z,
   input  logic                         csr_wen,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // Configuration registers
   pce_cfg_type cfg_ff;
   pce_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (pce_csr_type'(csr_index))
            CSR_KIND:   cfg_in.kind   = pce_kind_type'(csr_wdata[KIND_W-1:0]);
            CSR_AXIS_A: cfg_in.axis_a = csr_wdata[AXIS_W-1:0];
            CSR_AXIS_B: cfg_in.axis_b = csr_wdata[AXIS_W-1:0];
            CSR_PITCH:  cfg_in.pitch  = csr_wdata[AXIS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{kind: KIND_CIRCLE, axis_a: AXIS_RESET, axis_b: AXIS_RESET,
                     pitch: AXIS_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline
   logic                 advance;
   logic                 skid_valid_ff;
   pce_tag_type          rdc_tag;
   logic signed [CW-1:0] rdc_z;
   logic                 rdc_neg;
   pce_tag_type          cor_tag;
   logic signed [CW-1:0] cor_cos;
   logic signed [CW-1:0] cor_sin;
   logic                 cor_neg;
   logic                 res_valid;
   pce_op_type           res_op;
   pce_res_type          res;

   assign advance   = ~skid_valid_ff;
   assign req_ready = advance;

   pce_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_op    (pce_op_type'(req_operation)),
      .in_angle (req_angle),
      .out_tag  (rdc_tag),
      .out_z    (rdc_z),
      .out_neg  (rdc_neg)
   );

   pce_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_tag  (rdc_tag),
      .in_z    (rdc_z),
      .in_neg  (rdc_neg),
      .out_tag (cor_tag),
      .out_cos (cor_cos),
      .out_sin (cor_sin),
      .out_neg (cor_neg)
   );

   pce_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_tag    (cor_tag),
      .in_cos    (cor_cos),
      .in_sin    (cor_sin),
      .in_neg    (cor_neg),
      .out_valid (res_valid),
      .out_op    (res_op),
      .out_res   (res)
   );

   // Output register with skid
   pce_res_type fin;
   pce_res_type out_ff;
   pce_res_type out_in;
   pce_res_type skid_ff;
   pce_res_type skid_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        skid_valid_in;
   logic        out_take;
   logic        new_item;

   always_comb begin
      fin           = res;
      fin.x         = (res_op == OP_DERIV) ? -res.x : res.x;
      new_item      = advance & res_valid;
      out_take      = ~out_valid_ff | rsp_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (new_item) begin
         if (out_take) begin
            out_in       = fin;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = fin;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_ready) begin
         // drop the delivered response
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_coord_x = out_ff.x;
   assign rsp_coord_y = out_ff.y;
   assign rsp_coord_z = out_ff.z;

endmodule

@@ rtl/pce_checker.sv @@
module pce_checker import pce_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [OUT_W-1:0]   rsp_coord_x,
   input logic signed [OUT_W-1:0]   rsp_coord_y,
   input logic signed [OUT_W-1:0]   rsp_coord_z
);

   // Requests taken but not yet answered
   logic [7:0] pend_ff;
   logic [7:0] pend_in;

   always_comb begin
      pend_in = pend_ff + 8'(req_valid & req_ready) - 8'(rsp_valid & rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coord_x)
         && $stable(rsp_coord_y) && $stable(rsp_coord_z))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("response without an outstanding request");

   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no response waiting");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("request side stalled without a blocked response");

endmodule

bind parametric_curve_evaluator pce_checker u_pce_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_coord_x (rsp_coord_x),
   .rsp_coord_y (rsp_coord_y),
   .rsp_coord_z (rsp_coord_z)
);
